// ===== rtl/gaussian_mixture_log_likelihood_unit_assert.svh =====
// ----------------------------------------------------------------------------
// gaussian mixture log-likelihood unit assertion macros
// property wrappers for the block's checks, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_MIXTURE_LOG_LIKELIHOOD_UNIT_ASSERT_SVH
`define GAUSSIAN_MIXTURE_LOG_LIKELIHOOD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication on aclk, disabled in reset
`define GMLL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gmll: same-cycle check failed");

// next-cycle implication on aclk, disabled in reset
`define GMLL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gmll: next-cycle check failed");

`else

`define GMLL_ASSERT_IMPL(lbl, ante, cons)
`define GMLL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/gmll_pkg.sv =====
// ----------------------------------------------------------------------------
// gmll_pkg
// shared widths, constants and types of the mixture log-likelihood unit
// ----------------------------------------------------------------------------
`default_nettype none

package gmll_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int UNC_W  = 31;
    localparam int SUM_W  = 48;
    localparam int WGT_W  = 16;
    localparam int Q_W    = 47;
    localparam int PROD_W = 64;
    localparam int LACC_W = 40;
    localparam int STEP_W = 6;
    localparam int MANT_W = 31;
    localparam int ADDR_W = 3;

    // integer bits of the scaled residual before it is capped
    localparam int CAP_SH = Q_W - FRAC_BITS;
    // shift from the q30 domain down to the output fraction
    localparam int Q30_SH = 30 - FRAC_BITS;

    localparam longint LN2_Q30_L      = 744261118;
    localparam longint HALF_LN2PI_Q30 = 986702737;

    localparam logic [29:0] LN2_Q30 = 30'(LN2_Q30_L);

    // -(30 - FRAC_BITS) * ln2 - ln(2 pi) / 2, the fixed part of the log terms
    localparam logic signed [LACC_W-1:0] LACC_INIT =
        LACC_W'(-(longint'(Q30_SH) * LN2_Q30_L + HALF_LN2PI_Q30));

    localparam logic [SUM_W-1:0] A_CAP = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] D_FAR = SUM_W'(longint'(32) << FRAC_BITS);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [ADDR_W-1:0] ADDR_MIX_WEIGHT = 3'd0;
    localparam logic [WGT_W-1:0]  MIX_WEIGHT_RST  = 16'd32768;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] rem;
        logic [PROD_W-1:0] den;
        logic [Q_W-1:0]    dlo;
        logic [STEP_W-1:0] steps;
    } gmll_div_req_t;

    typedef struct packed {
        logic              done;
        logic [Q_W-1:0]    quo;
        logic [PROD_W-1:0] rem;
    } gmll_div_rsp_t;

    // floor(2^32 / n) for the series divisors
    function automatic logic [31:0] gmll_recip(input logic [4:0] n);
        logic [31:0] r;
        case (n)
            5'd2:    r = 32'd2147483648;
            5'd3:    r = 32'd1431655765;
            5'd4:    r = 32'd1073741824;
            5'd5:    r = 32'd858993459;
            5'd6:    r = 32'd715827882;
            5'd7:    r = 32'd613566756;
            5'd8:    r = 32'd536870912;
            5'd9:    r = 32'd477218588;
            5'd10:   r = 32'd429496729;
            5'd11:   r = 32'd390451572;
            5'd12:   r = 32'd357913941;
            5'd13:   r = 32'd330382099;
            5'd15:   r = 32'd286331153;
            5'd17:   r = 32'd252645135;
            5'd19:   r = 32'd226050910;
            5'd21:   r = 32'd204522252;
            5'd23:   r = 32'd186737708;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gmll_div.sv =====
// ----------------------------------------------------------------------------
// gmll_div
// restoring divider, one quotient bit per cycle, remainder kept
// ----------------------------------------------------------------------------
`default_nettype none

module gmll_div
    import gmll_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire gmll_div_req_t req,
    output gmll_div_rsp_t      rsp
);

    logic [PROD_W-1:0] rem_reg, rem_next;
    logic [PROD_W-1:0] den_reg, den_next;
    logic [Q_W-1:0]    dlo_reg, dlo_next;
    logic [Q_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [PROD_W:0] rem_sh;
    logic [PROD_W:0] rem_sub;
    logic            fits;

    // shift in the next dividend bit, msb first
    assign rem_sh  = {rem_reg, dlo_reg[Q_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        dlo_next  = dlo_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem;
            den_next  = req.den;
            dlo_next  = req.dlo;
            quo_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? rem_sub[PROD_W-1:0] : rem_sh[PROD_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
            dlo_next = {dlo_reg[Q_W-2:0], 1'b0};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dlo_reg <= dlo_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/gaussian_mixture_log_likelihood_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_mixture_log_likelihood_unit
// two-component gaussian mixture log-likelihood, summed over a data set
// ----------------------------------------------------------------------------
//  channel   dir  ports             content
//  s_        in   tdata/tlast       observation, two predictions, sigma, last
//  m_        out  tdata/tuser       log-likelihood sum, saturation flag
//  apb       in   psel..prdata      mix_weight at byte address 0
//
//  a zero weight or zero sigma, or a capped base residual, ends a point
//  early; otherwise the work is the restoring divider (47 steps per
//  residual, 30 per log), the normalize shifts and the two 12-term
//  series on the shared 32x32 multiplier.
//  s_tready is high only while idle; a finished sum waits in the output
//  register and stalls the block only when the next sum is due.
//  reset is synchronous, active low, and clears the sum and flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_mixture_log_likelihood_unit_assert.svh"

module gaussian_mixture_log_likelihood_unit
    import gmll_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // observation, prediction_first, prediction_second, uncertainty, zero pad
    input  wire logic [127:0]      s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // log_likelihood_sum
    output logic [SUM_W-1:0]       m_tdata,
    // saturated
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQS   = 5'd1;
    localparam logic [4:0] S_DEN   = 5'd2;
    localparam logic [4:0] S_MAG   = 5'd3;
    localparam logic [4:0] S_SQR   = 5'd4;
    localparam logic [4:0] S_NUM   = 5'd5;
    localparam logic [4:0] S_DIV   = 5'd6;
    localparam logic [4:0] S_ADONE = 5'd7;
    localparam logic [4:0] S_SEL   = 5'd8;
    localparam logic [4:0] S_EXP0  = 5'd9;
    localparam logic [4:0] S_TMUL  = 5'd10;
    localparam logic [4:0] S_TSH   = 5'd11;
    localparam logic [4:0] S_DS0   = 5'd12;
    localparam logic [4:0] S_DS1   = 5'd13;
    localparam logic [4:0] S_DS2   = 5'd14;
    localparam logic [4:0] S_TFIN  = 5'd15;
    localparam logic [4:0] S_EXPF  = 5'd16;
    localparam logic [4:0] S_SM    = 5'd17;
    localparam logic [4:0] S_SMA   = 5'd18;
    localparam logic [4:0] S_NORM  = 5'd19;
    localparam logic [4:0] S_LN0   = 5'd20;
    localparam logic [4:0] S_LZ    = 5'd21;
    localparam logic [4:0] S_LZ2   = 5'd22;
    localparam logic [4:0] S_FIN   = 5'd23;
    localparam logic [4:0] S_ACC   = 5'd24;
    localparam logic [4:0] S_KEST  = 5'd25;
    localparam logic [4:0] S_KQ    = 5'd26;
    localparam logic [4:0] S_KMUL  = 5'd27;

    localparam logic [1:0] DCTX_A   = 2'd0;
    localparam logic [1:0] DCTX_LN  = 2'd2;

    localparam int X_W  = 35;
    localparam int TW   = SUM_W + 2;
    localparam logic [3:0] LAST_STEP = 4'd11;
    // floor(2^46 / ln2 in q30), k estimate from d in q16, low by at most one
    localparam logic [31:0] LN2_RECIP = 32'd94548;

    // control
    logic [4:0]       state_reg, state_next;
    logic [WGT_W-1:0] mix_weight_reg, mix_weight_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic             sat_reg, sat_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [DATA_W-1:0] obs_reg, obs_next;
    logic [DATA_W-1:0] p1_reg, p1_next;
    logic [DATA_W-1:0] p2_reg, p2_next;
    logic [UNC_W-1:0]  unc_reg, unc_next;
    logic              last_reg, last_next;
    logic              comp_reg, comp_next;
    logic [DATA_W-1:0] mag_reg, mag_next;
    logic [PROD_W-1:0] den_reg, den_next;
    logic [SUM_W-1:0]  a1_reg, a1_next;
    logic [SUM_W-1:0]  a2_reg, a2_next;
    logic              cap1_reg, cap1_next;
    logic              cap2_reg, cap2_next;
    logic [SUM_W-1:0]  ab_reg, ab_next;
    logic [16:0]       wb_reg, wb_next;
    logic [16:0]       wo_reg, wo_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [30:0]       t_reg, t_next;
    logic [29:0]       k_reg, k_next;
    logic [30:0]       v_reg, v_next;
    logic [30:0]       q0_reg, q0_next;
    logic [30:0]       q_reg, q_next;
    logic [32:0]       acc_reg, acc_next;
    logic [3:0]        stp_reg, stp_next;
    logic              ser_ln_reg, ser_ln_next;
    logic [5:0]        kexp_reg, kexp_next;
    logic [31:0]       e_reg, e_next;
    logic [MANT_W-1:0] mant_reg, mant_next;
    logic              ph_s_reg, ph_s_next;
    logic signed [LACC_W-1:0] lacc_reg, lacc_next;
    logic signed [SUM_W-1:0]  term_reg, term_next;
    logic [1:0]        dctx_reg, dctx_next;
    logic [SUM_W-1:0]  out_sum_reg, out_sum_next;
    logic              out_sat_reg, out_sat_next;

    gmll_div_req_t div_req;
    gmll_div_rsp_t div_rsp;

    logic [31:0]        mul_a, mul_b;
    logic               cfg_wr;
    logic               in_acc;
    logic               out_load;
    logic [16:0]        w1, w2;
    logic signed [32:0] res_s;
    logic [32:0]        res_neg;
    logic               num_cap;
    logic               a1_le;
    logic [SUM_W-1:0]   a_base, a_other, d_val;
    logic [X_W-1:0]     x_val;
    logic [X_W-1:0]     x_red;
    logic [4:0]         div_n;
    logic [31:0]        rmd;
    logic [31:0]        sm_val;
    logic signed [LACC_W-1:0] small_v;
    logic signed [TW-1:0]     term_w;
    logic signed [SUM_W:0]    sum_w;

    gmll_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_MIX_WEIGHT);
    assign prdata   = (paddr == ADDR_MIX_WEIGHT) ? {16'd0, mix_weight_reg} : 32'd0;
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_sat_reg;

    assign w1 = {1'b0, mix_weight_reg};
    assign w2 = 17'h10000 - w1;

    assign res_s   = comp_reg ? ($signed({obs_reg[31], obs_reg}) - $signed({p2_reg[31], p2_reg}))
                              : ($signed({obs_reg[31], obs_reg}) - $signed({p1_reg[31], p1_reg}));
    assign res_neg = 33'(-res_s);

    assign num_cap = {{CAP_SH{1'b0}}, prod_reg} >= {den_reg, {CAP_SH{1'b0}}};

    assign a1_le   = a1_reg <= a2_reg;
    assign a_base  = a1_le ? a1_reg : a2_reg;
    assign a_other = a1_le ? a2_reg : a1_reg;
    assign d_val   = a_other - a_base;
    assign x_val   = {d_val[FRAC_BITS+4:0], {Q30_SH{1'b0}}};
    // rest after removing k * ln2, k from the reciprocal estimate
    assign x_red   = x_val - prod_reg[X_W-1:0];

    assign div_n = ser_ln_reg ? {stp_reg, 1'b1} : (5'(stp_reg) + 5'd1);
    assign rmd   = {1'b0, v_reg} - prod_reg[31:0];

    assign sm_val  = {2'b00, wb_reg[15:0], 14'd0} + prod_reg[47:16];
    assign small_v = lacc_reg >>> Q30_SH;
    assign term_w  = TW'(small_v) - $signed({2'b00, ab_reg});
    assign sum_w   = $signed({sum_reg[SUM_W-1], sum_reg}) + $signed({term_reg[SUM_W-1], term_reg});

    assign out_load = (state_reg == S_ACC) && last_reg && (!out_valid_reg || m_tready);

    // shared multiplier operands
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_SQS: begin
                mul_a = {1'b0, unc_reg};
                mul_b = {1'b0, unc_reg};
            end
            S_SQR: begin
                mul_a = mag_reg;
                mul_b = mag_reg;
            end
            S_KEST: begin
                mul_a = {{(32-FRAC_BITS-5){1'b0}}, d_val[FRAC_BITS+4:0]};
                mul_b = LN2_RECIP;
            end
            S_KMUL: begin
                mul_a = {26'd0, kexp_reg};
                mul_b = {2'b00, LN2_Q30};
            end
            S_TMUL: begin
                mul_a = {1'b0, t_reg};
                mul_b = {2'b00, k_reg};
            end
            S_DS0: begin
                mul_a = {1'b0, v_reg};
                mul_b = gmll_recip(div_n);
            end
            S_DS1: begin
                mul_a = prod_reg[63:32];
                mul_b = {27'd0, div_n};
            end
            S_SM: begin
                mul_a = {15'd0, wo_reg};
                mul_b = e_reg;
            end
            S_LZ: begin
                mul_a = {1'b0, t_reg};
                mul_b = {1'b0, t_reg};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        state_next      = state_reg;
        mix_weight_next = cfg_wr ? pwdata[WGT_W-1:0] : mix_weight_reg;
        sum_next        = sum_reg;
        sat_next        = sat_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        obs_next        = obs_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        unc_next        = unc_reg;
        last_next       = last_reg;
        comp_next       = comp_reg;
        mag_next        = mag_reg;
        den_next        = den_reg;
        a1_next         = a1_reg;
        a2_next         = a2_reg;
        cap1_next       = cap1_reg;
        cap2_next       = cap2_reg;
        ab_next         = ab_reg;
        wb_next         = wb_reg;
        wo_next         = wo_reg;
        t_next          = t_reg;
        k_next          = k_reg;
        v_next          = v_reg;
        q0_next         = q0_reg;
        q_next          = q_reg;
        acc_next        = acc_reg;
        stp_next        = stp_reg;
        ser_ln_next     = ser_ln_reg;
        kexp_next       = kexp_reg;
        e_next          = e_reg;
        mant_next       = mant_reg;
        ph_s_next       = ph_s_reg;
        lacc_next       = lacc_reg;
        term_next       = term_reg;
        dctx_next       = dctx_reg;
        out_sum_next    = out_sum_reg;
        out_sat_next    = out_sat_reg;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    obs_next   = s_tdata[31:0];
                    p1_next    = s_tdata[63:32];
                    p2_next    = s_tdata[95:64];
                    unc_next   = s_tdata[126:96];
                    last_next  = s_tlast;
                    state_next = S_SQS;
                end
            end
            S_SQS: begin
                if (unc_reg == '0 || mix_weight_reg == '0) begin
                    term_next  = SUM_MIN;
                    sat_next   = 1'b1;
                    state_next = S_ACC;
                end else begin
                    state_next = S_DEN;
                end
            end
            S_DEN: begin
                den_next   = {prod_reg[PROD_W-2:0], 1'b0};
                comp_next  = 1'b0;
                state_next = S_MAG;
            end
            S_MAG: begin
                mag_next   = res_s[32] ? res_neg[31:0] : res_s[31:0];
                state_next = S_SQR;
            end
            S_SQR: begin
                state_next = S_NUM;
            end
            S_NUM: begin
                if (num_cap) begin
                    if (comp_reg) begin
                        a2_next    = A_CAP;
                        cap2_next  = 1'b1;
                        state_next = S_SEL;
                    end else begin
                        a1_next    = A_CAP;
                        cap1_next  = 1'b1;
                        comp_next  = 1'b1;
                        state_next = S_MAG;
                    end
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem   = prod_reg >> CAP_SH;
                    div_req.den   = den_reg;
                    div_req.dlo   = Q_W'({prod_reg, {FRAC_BITS{1'b0}}});
                    div_req.steps = STEP_W'(Q_W);
                    dctx_next     = DCTX_A;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    case (dctx_reg)
                        DCTX_A:   state_next = S_ADONE;
                        default:  state_next = S_LN0;
                    endcase
                end
            end
            S_ADONE: begin
                if (comp_reg) begin
                    a2_next    = {1'b0, div_rsp.quo};
                    cap2_next  = 1'b0;
                    state_next = S_SEL;
                end else begin
                    a1_next    = {1'b0, div_rsp.quo};
                    cap1_next  = 1'b0;
                    comp_next  = 1'b1;
                    state_next = S_MAG;
                end
            end
            S_SEL: begin
                ab_next = a_base;
                wb_next = a1_le ? w1 : w2;
                wo_next = a1_le ? w2 : w1;
                if (a1_le ? cap1_reg : cap2_reg) begin
                    term_next  = SUM_MIN;
                    sat_next   = 1'b1;
                    state_next = S_ACC;
                end else if (d_val >= D_FAR) begin
                    e_next     = 32'd0;
                    state_next = S_SM;
                end else begin
                    // range reduction: d = k * ln2 + rest
                    state_next = S_KEST;
                end
            end
            S_KEST: begin
                state_next = S_KQ;
            end
            S_KQ: begin
                kexp_next  = prod_reg[37:32];
                state_next = S_KMUL;
            end
            S_KMUL: begin
                state_next = S_EXP0;
            end
            S_EXP0: begin
                if (x_red >= X_W'(LN2_Q30)) begin
                    kexp_next = kexp_reg + 6'd1;
                    k_next    = LN2_Q30 - 30'(x_red - X_W'(LN2_Q30));
                end else begin
                    k_next    = LN2_Q30 - x_red[29:0];
                end
                t_next      = 31'h4000_0000;
                acc_next    = 33'h0_4000_0000;
                stp_next    = 4'd0;
                ser_ln_next = 1'b0;
                state_next  = S_TMUL;
            end
            S_TMUL: begin
                state_next = S_TSH;
            end
            S_TSH: begin
                t_next     = prod_reg[60:30];
                v_next     = prod_reg[60:30];
                state_next = S_DS0;
            end
            S_DS0: begin
                if (div_n == 5'd1) begin
                    q_next     = v_reg;
                    state_next = S_TFIN;
                end else begin
                    state_next = S_DS1;
                end
            end
            S_DS1: begin
                q0_next    = prod_reg[62:32];
                state_next = S_DS2;
            end
            S_DS2: begin
                // reciprocal estimate is low by at most one
                q_next     = q0_reg + 31'((rmd >= {27'd0, div_n}) ? 1 : 0);
                state_next = S_TFIN;
            end
            S_TFIN: begin
                acc_next = acc_reg + {2'b00, q_reg};
                stp_next = stp_reg + 4'd1;
                if (!ser_ln_reg) begin
                    t_next = q_reg;
                end
                if (stp_reg != LAST_STEP) begin
                    state_next = S_TMUL;
                end else if (!ser_ln_reg) begin
                    state_next = S_EXPF;
                end else begin
                    lacc_next = ph_s_reg
                        ? lacc_reg - $signed(LACC_W'({acc_next, 1'b0}))
                        : lacc_reg + $signed(LACC_W'({acc_next, 1'b0}));
                    if (!ph_s_reg) begin
                        mant_next  = unc_reg;
                        ph_s_next  = 1'b1;
                        state_next = S_NORM;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_EXPF: begin
                e_next     = 32'(acc_reg >> ({1'b0, kexp_reg} + 7'd1));
                state_next = S_SM;
            end
            S_SM: begin
                state_next = S_SMA;
            end
            S_SMA: begin
                mant_next  = sm_val[MANT_W-1:0];
                lacc_next  = LACC_INIT;
                ph_s_next  = 1'b0;
                state_next = S_NORM;
            end
            S_NORM: begin
                if (mant_reg[MANT_W-1]) begin
                    // z = (m - 1) / (m + 1) in q30
                    div_req.start = 1'b1;
                    div_req.rem   = PROD_W'(mant_reg[29:0]);
                    div_req.den   = PROD_W'({1'b1, mant_reg[29:0]}) + PROD_W'(32'h4000_0000);
                    div_req.dlo   = '0;
                    div_req.steps = STEP_W'(30);
                    dctx_next     = DCTX_LN;
                    state_next    = S_DIV;
                end else begin
                    mant_next = {mant_reg[MANT_W-2:0], 1'b0};
                    lacc_next = ph_s_reg ? lacc_reg + $signed(LACC_W'(LN2_Q30))
                                         : lacc_reg - $signed(LACC_W'(LN2_Q30));
                end
            end
            S_LN0: begin
                t_next     = div_rsp.quo[30:0];
                state_next = S_LZ;
            end
            S_LZ: begin
                state_next = S_LZ2;
            end
            S_LZ2: begin
                k_next      = prod_reg[59:30];
                v_next      = t_reg;
                stp_next    = 4'd0;
                ser_ln_next = 1'b1;
                acc_next    = '0;
                state_next  = S_DS0;
            end
            S_FIN: begin
                if (term_w < TW'(SUM_MIN)) begin
                    term_next = SUM_MIN;
                    sat_next  = 1'b1;
                end else if (term_w > TW'(SUM_MAX)) begin
                    term_next = SUM_MAX;
                    sat_next  = 1'b1;
                end else begin
                    term_next = term_w[SUM_W-1:0];
                end
                state_next = S_ACC;
            end
            S_ACC: begin
                if (!last_reg || out_load) begin
                    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
                        sum_next = sum_w[SUM_W] ? SUM_MIN : SUM_MAX;
                        sat_next = 1'b1;
                    end else begin
                        sum_next = sum_w[SUM_W-1:0];
                    end
                    if (last_reg) begin
                        out_sum_next   = sum_next;
                        out_sat_next   = sat_next;
                        out_valid_next = 1'b1;
                        sum_next       = '0;
                        sat_next       = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mix_weight_reg <= MIX_WEIGHT_RST;
            sum_reg        <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mix_weight_reg <= mix_weight_next;
            sum_reg        <= sum_next;
            sat_reg        <= sat_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        obs_reg     <= obs_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        unc_reg     <= unc_next;
        last_reg    <= last_next;
        comp_reg    <= comp_next;
        mag_reg     <= mag_next;
        den_reg     <= den_next;
        a1_reg      <= a1_next;
        a2_reg      <= a2_next;
        cap1_reg    <= cap1_next;
        cap2_reg    <= cap2_next;
        ab_reg      <= ab_next;
        wb_reg      <= wb_next;
        wo_reg      <= wo_next;
        prod_reg    <= prod_next;
        t_reg       <= t_next;
        k_reg       <= k_next;
        v_reg       <= v_next;
        q0_reg      <= q0_next;
        q_reg       <= q_next;
        acc_reg     <= acc_next;
        stp_reg     <= stp_next;
        ser_ln_reg  <= ser_ln_next;
        kexp_reg    <= kexp_next;
        e_reg       <= e_next;
        mant_reg    <= mant_next;
        ph_s_reg    <= ph_s_next;
        lacc_reg    <= lacc_next;
        term_reg    <= term_next;
        dctx_reg    <= dctx_next;
        out_sum_reg <= out_sum_next;
        out_sat_reg <= out_sat_next;
    end

    `GMLL_ASSERT_NEXT(a_busy_after_request, in_acc, !s_tready)
    `GMLL_ASSERT_IMPL(a_cap_value, state_reg == S_SEL, (!cap1_reg || a1_reg == A_CAP) && (!cap2_reg || a2_reg == A_CAP))
    `GMLL_ASSERT_NEXT(a_sum_cleared, out_load, sum_reg == '0 && !sat_reg && m_tvalid)
    `GMLL_ASSERT_IMPL(a_norm_nonzero, state_reg == S_NORM, mant_reg != '0)

endmodule

`default_nettype wire

// ===== tb/gaussian_mixture_log_likelihood_unit_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian mixture log-likelihood unit testbench
// drives data points over the input stream and checks each emitted sum and
// saturation flag against a bit-exact predictor, across weight settings and
// sender and receiver stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_mixture_log_likelihood_unit_tb
    import gmll_pkg::*;
();

    localparam longint unsigned Q30_ONE   = 64'd1 << 30;
    localparam longint          LL_MAX    = (64'sd1 <<< 47) - 1;
    localparam longint          LL_MIN    = -(64'sd1 <<< 47);
    localparam int              STALL_MAX = 5000;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic             sat;
    } set_result_t;

    logic              aclk;
    logic              aresetn;
    logic [127:0]      s_tdata;
    logic              s_tlast;
    logic              s_tvalid;
    logic              s_tready;
    logic [SUM_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [WGT_W-1:0]  weight_now;
    longint            set_total;
    bit                set_sat;
    set_result_t       pending_sums[$];

    int  src_idle_pct;
    int  snk_stall_pct;
    int  errors;
    int  points_sent;
    int  sums_checked;
    int  quiet_cycles;

    gaussian_mixture_log_likelihood_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int msb_pos(longint unsigned v);
        int p;
        p = 0;
        while (v > 1) begin
            v = v >> 1;
            p++;
        end
        return p;
    endfunction

    // ln of a q30 mantissa in [1, 2) by the atanh series
    function automatic longint unsigned ln_mantissa(longint unsigned m);
        longint unsigned z, z2, pw, acc;
        z   = ((m - Q30_ONE) << 30) / (m + Q30_ONE);
        z2  = (z * z) >> 30;
        pw  = z;
        acc = 0;
        for (int k = 0; k < 12; k++) begin
            acc += pw / longint'(2 * k + 1);
            pw = (pw * z2) >> 30;
        end
        return acc * 2;
    endfunction

    function automatic longint unsigned exp_of_neg(longint unsigned d);
        longint unsigned x, k, y, term, acc;
        x    = d << (30 - FRAC_BITS);
        k    = x / LN2_Q30_L;
        y    = LN2_Q30_L - (x - k * LN2_Q30_L);
        term = Q30_ONE;
        acc  = Q30_ONE;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * y) >> 30) / longint'(n);
            acc += term;
        end
        return acc >> (k + 1);
    endfunction

    // r^2 / (2 s^2) with truncated fraction, capped for huge residuals
    function automatic longint unsigned scaled_residual(longint r, longint unsigned s,
                                                        output bit capped);
        longint unsigned mag, num, den, q, rem, frac;
        mag  = (r < 0) ? longint'(-r) : longint'(r);
        num  = mag * mag;
        den  = 2 * s * s;
        q    = num / den;
        rem  = num % den;
        frac = 0;
        if (q >= (64'd1 << (47 - FRAC_BITS))) begin
            capped = 1'b1;
            return 64'd1 << 47;
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
                rem  = rem - den;
                frac = frac | 1;
            end
        end
        capped = 1'b0;
        return (q << FRAC_BITS) | frac;
    endfunction

    function automatic longint q30_floor(longint v);
        int sh;
        sh = 30 - FRAC_BITS;
        if (v >= 0) return v >>> sh;
        return -((-v + ((64'sd1 <<< sh) - 1)) >>> sh);
    endfunction

    function automatic void predict_point(logic [31:0] y_raw, logic [31:0] m1_raw,
                                          logic [31:0] m2_raw, logic [30:0] s_raw,
                                          logic last);
        longint          y, m1, m2, term, ln_sm, ln_s, frac_part;
        longint unsigned s, a1, a2, ab, ao, wb, wo, e, sm, mant;
        bit              cap1, cap2, capb;
        int              p;
        set_result_t     r;
        y  = longint'($signed(y_raw));
        m1 = longint'($signed(m1_raw));
        m2 = longint'($signed(m2_raw));
        s  = longint'(s_raw);
        if (s == 0 || weight_now == 0) begin
            term    = LL_MIN;
            set_sat = 1'b1;
        end else begin
            a1 = scaled_residual(y - m1, s, cap1);
            a2 = scaled_residual(y - m2, s, cap2);
            if (a1 <= a2) begin
                ab = a1; ao = a2; capb = cap1;
                wb = weight_now; wo = 65536 - weight_now;
            end else begin
                ab = a2; ao = a1; capb = cap2;
                wb = 65536 - weight_now; wo = weight_now;
            end
            if (capb) begin
                term    = LL_MIN;
                set_sat = 1'b1;
            end else begin
                e     = (ao - ab >= (64'd32 << FRAC_BITS)) ? 0 : exp_of_neg(ao - ab);
                sm    = (wb << 14) + ((wo * e) >> 16);
                p     = msb_pos(sm);
                mant  = sm << (30 - p);
                ln_sm = longint'(p - 30) * LN2_Q30_L + longint'(ln_mantissa(mant));
                p     = msb_pos(s);
                mant  = s << (30 - p);
                ln_s  = longint'(p - FRAC_BITS) * LN2_Q30_L + longint'(ln_mantissa(mant));
                frac_part = q30_floor(ln_sm - ln_s - HALF_LN2PI_Q30);
                term  = frac_part - longint'(ab);
                if (term < LL_MIN) begin term = LL_MIN; set_sat = 1'b1; end
                if (term > LL_MAX) begin term = LL_MAX; set_sat = 1'b1; end
            end
        end
        set_total += term;
        if (set_total < LL_MIN) begin set_total = LL_MIN; set_sat = 1'b1; end
        if (set_total > LL_MAX) begin set_total = LL_MAX; set_sat = 1'b1; end
        if (last) begin
            r.total = set_total[SUM_W-1:0];
            r.sat   = set_sat;
            pending_sums.push_back(r);
            set_total = 0;
            set_sat   = 1'b0;
        end
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_point(logic [31:0] y, logic [31:0] m1, logic [31:0] m2,
                              logic [30:0] s, logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {1'b0, s, m2, m1, y};
        s_tlast  = last;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_point(y, m1, m2, s, last);
        points_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_sums();
        s_tvalid = 1'b0;
        while (pending_sums.size() != 0) @(negedge aclk);
        // a point without a sum may still be in flight
        repeat (500) @(negedge aclk);
    endtask

    task automatic write_weight(logic [WGT_W-1:0] w);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_MIX_WEIGHT;
        pwdata  = {16'd0, w};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        weight_now = w;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic test_directed();
        logic [30:0] one;
        one = 31'h0001_0000;
        send_point(32'h0, 32'h0, 32'h0, one, 1'b1);                    // tie, exact fit
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'd1, 1'b1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 1'b1);
        send_point(32'h0, 32'h0, 32'h0, 31'd0, 1'b1);                  // zero sigma
        send_point(32'h0001_0000, 32'h0, 32'h0002_0000, one, 1'b0);
        send_point(32'h0, 32'h0, 32'h000a_0000, one, 1'b0);            // far components
        send_point(32'h0, 32'h000a_0000, 32'h0, one, 1'b1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'd1, 1'b1); // base capped
        send_point(32'h0, 32'h0, 32'h7fff_ffff, 31'd1, 1'b1);          // other capped
        // sum overflow toward minus
        send_point(32'h0, 32'h0, 32'h0, 31'd0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 31'd0, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, one, 1'b1);
        // tiny sigma gives a large positive log term
        send_point(32'h0, 32'h0, 32'h0, 31'd1, 1'b0);
        send_point(32'h0, 32'h0, 32'h0, 31'd1, 1'b1);
        send_point(32'hffff_ffff, 32'h0, 32'h1, 31'h4000_0000, 1'b1);
        drain_sums();
    endtask

    task automatic test_weights();
        logic [WGT_W-1:0] wset[4];
        wset = '{16'd0, 16'd1, 16'd65535, 16'd32768};
        foreach (wset[i]) begin
            write_weight(wset[i]);
            send_point(32'h0001_0000, 32'h0, 32'h0003_0000, 31'h0001_0000, 1'b0);
            send_point(32'h0, 32'h0004_0000, 32'h0, 31'h0000_8000, 1'b0);
            send_point(32'h0, 32'h0, 32'h0, 31'h0001_0000, 1'b1);
            drain_sums();
        end
    endtask

    task automatic test_random(int n, int idle, int stall);
        int          set_len, pos, kind;
        logic [31:0] y, m1, m2, d1, d2;
        logic [30:0] s;
        src_idle_pct  = idle;
        snk_stall_pct = stall;
        set_len = $urandom_range(1, 6);
        pos     = 0;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            y    = $urandom_range(32'h0100_0000) - 32'h0080_0000;
            s    = 31'($urandom_range(32'h0010_0000, 32'h0000_1000));
            d1   = $urandom_range(32'h0008_0000) - 32'h0004_0000;
            d2   = $urandom_range(32'h0040_0000) - 32'h0020_0000;
            if (kind < 65) begin
                m1 = y + ((d1 * 32'(s)) >>> 16);
                m2 = y + d2;
            end else if (kind < 80) begin
                y  = $urandom;
                m1 = $urandom;
                m2 = $urandom;
                s  = 31'($urandom);
            end else if (kind < 88) begin
                m1 = y + d1;
                m2 = y - d1;
                s  = ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom_range(255));
            end else begin
                // components far apart relative to sigma
                s  = 31'($urandom_range(32'h0001_0000, 32'h0000_4000));
                m1 = y + 32'(d1[15:0]);
                m2 = y + (d2 | 32'h0010_0000);
            end
            pos++;
            send_point(y, m1, m2, s, pos == set_len || i == n - 1);
            if (pos == set_len) begin
                pos     = 0;
                set_len = $urandom_range(1, 6);
            end
        end
        drain_sums();
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        set_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: sum with none expected: actual %h/%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_sums.pop_front();
                if (m_tdata !== want.total) begin
                    $display("%0t: log_likelihood_sum expected %h actual %h",
                             $time, want.total, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser);
                    errors++;
                end
                sums_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake on either stream and no bus access
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("watchdog expired at %0t", $time);
            $display("gaussian_mixture_log_likelihood_unit: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        s_tvalid      = 1'b0;
        m_tready      = 1'b1;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        weight_now    = MIX_WEIGHT_RST;
        set_total     = 0;
        set_sat       = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        errors        = 0;
        points_sent   = 0;
        sums_checked  = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_weights();
        test_random(400, 0, 0);
        write_weight(16'($urandom_range(65535)));
        test_random(400, 59, 0);
        write_weight(16'($urandom_range(65535)));
        test_random(400, 0, 59);
        write_weight(16'd32768);
        test_random(400, 12, 12);
        $display("sent %0d points, checked %0d set sums over weight extremes and stall mixes",
                 points_sent, sums_checked);
        if (errors == 0 && pending_sums.size() == 0)
            $display("gaussian_mixture_log_likelihood_unit: match");
        else
            $display("gaussian_mixture_log_likelihood_unit: mismatch");
        $finish;
    end

endmodule
